### hdl/upnp_pkg.sv
package upnp_pkg;

    localparam int MAX_LENGTH_DEF = 4096;

    localparam int CHAR_W = 8;
    localparam int PORT_W = 16;
    localparam int POS_W  = 13;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_SPECIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILING_CHECK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME_PORT    = 2'd2;

    localparam logic              RST_SCHEME_SPECIAL = 1'b1;
    localparam logic              RST_TRAILING_CHECK = 1'b1;
    localparam logic [PORT_W-1:0] RST_SCHEME_PORT    = 16'd80;

    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_QUESTION  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_ZERO      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE      = 8'h39;

    localparam logic [19:0] PORT_LIMIT = 20'd65535;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_INVALID,
        ST_OVERFLOW
    } status_t;

    typedef struct packed {
        phase_t            phase;
        logic [PORT_W-1:0] acc;
        logic              digit_seen;
        status_t           dstatus;
    } scan_t;

    typedef struct packed {
        logic              scheme_is_special;
        logic              trailing_check_on;
        logic [PORT_W-1:0] scheme_port;
    } cfg_t;

endpackage

### hdl/upnp_step.sv
module upnp_step
    import upnp_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF,
    parameter int IDX_W      = $clog2(MAX_LENGTH + 1)
)
(
    input  cfg_t              cfg,
    input  scan_t             cur,
    input  logic [IDX_W-1:0]  cur_index,
    input  logic [IDX_W-1:0]  cur_dpos,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              final_char,
    input  logic              empty_string,
    output scan_t             nxt,
    output logic [IDX_W-1:0]  nxt_index,
    output logic [IDX_W-1:0]  nxt_dpos,
    output logic              res_valid,
    output status_t           res_status,
    output logic              res_present,
    output logic [PORT_W-1:0] res_port,
    output logic [IDX_W-1:0]  res_pos
);

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LENGTH);

    scan_t            taken;
    logic [IDX_W-1:0] taken_index;
    logic [IDX_W-1:0] taken_dpos;
    logic [19:0]      acc_next;
    logic             ok_term;

    // State after the byte of this word has been taken.
    always_comb
    begin
        taken       = cur;
        taken_index = cur_index;
        taken_dpos  = cur_dpos;
        acc_next    = 20'(cur.acc) * 20'd10 + 20'(char_code[3:0]);
        ok_term     = (char_code == CH_SLASH) || (char_code == CH_QUESTION) ||
                      (cfg.scheme_is_special && char_code == CH_BACKSLASH);
        if (!empty_string)
        begin
            if (cur_index != IDX_MAX)
            begin
                taken_index = cur_index + IDX_W'(1);
            end
            if (cur.phase != PH_DONE && !(char_code inside {CH_TAB, CH_LF, CH_CR}))
            begin
                if (cur.phase == PH_LEAD && char_code == CH_MINUS)
                begin
                    taken.phase   = PH_DONE;
                    taken.dstatus = ST_INVALID;
                    taken_dpos    = '0;
                end
                else
                begin
                    taken.phase = PH_DIGITS;
                    if (char_code inside {[CH_ZERO:CH_NINE]})
                    begin
                        taken.digit_seen = 1'b1;
                        if (acc_next > PORT_LIMIT)
                        begin
                            taken.phase   = PH_DONE;
                            taken.dstatus = ST_OVERFLOW;
                            taken_dpos    = '0;
                        end
                        else
                        begin
                            taken.acc = acc_next[PORT_W-1:0];
                        end
                    end
                    else
                    begin
                        taken.phase   = PH_DONE;
                        taken.dstatus = (!cfg.trailing_check_on || ok_term) ? ST_OK
                                                                           : ST_INVALID;
                        taken_dpos    = cur_index;
                    end
                end
            end
        end
    end

    // Result of the substring, and the return to the cleared state after it.
    always_comb
    begin
        res_valid   = final_char || empty_string;
        res_present = 1'b0;
        res_port    = '0;
        if (taken.phase == PH_DONE)
        begin
            res_status = taken.dstatus;
            res_pos    = taken_dpos;
        end
        else
        begin
            res_status = ST_OK;
            res_pos    = taken_index;
        end
        if (res_status == ST_OK && taken.digit_seen &&
            (cfg.scheme_port != taken.acc ||
             (cfg.scheme_port == '0 && taken.acc == '0)))
        begin
            res_present = 1'b1;
            res_port    = taken.acc;
        end

        if (res_valid)
        begin
            nxt.phase      = PH_LEAD;
            nxt.acc        = '0;
            nxt.digit_seen = 1'b0;
            nxt.dstatus    = ST_OK;
            nxt_index      = '0;
            nxt_dpos       = '0;
        end
        else
        begin
            nxt       = taken;
            nxt_index = taken_index;
            nxt_dpos  = taken_dpos;
        end
    end

endmodule

### hdl/url_port_number_parser_core.sv
// Streaming URL port parser. One byte of the port substring is taken per word and a new word
// can be accepted in every clock cycle while the input does not stall. A word sits in an
// input register while the parse step works on it, and when the step advances, the result of
// the word that carries final_char or empty_string is loaded into the output register. The
// input stalls only while a finished result waits behind a held output register. Tab, LF
// and CR are skipped; positions saturate at MAX_LENGTH.
// Configuration registers must be written only while no substring is in progress.
module url_port_number_parser_core
    import upnp_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic                 final_char,
    input  logic                 empty_string,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic                 port_present,
    output logic [PORT_W-1:0]    port_value,
    output logic [POS_W-1:0]     stop_position
);

    localparam int IDX_W = $clog2(MAX_LENGTH + 1);

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_final_reg;
    logic              s1_empty_reg;
    scan_t             scan_reg;
    scan_t             scan_next;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic [IDX_W-1:0]  dpos_reg;
    logic [IDX_W-1:0]  dpos_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic              present_reg;
    logic [PORT_W-1:0] port_reg;
    logic [IDX_W-1:0]  pos_reg;

    logic              res_valid;
    status_t           res_status;
    logic              res_present;
    logic [PORT_W-1:0] res_port;
    logic [IDX_W-1:0]  res_pos;
    logic              s1_adv;
    logic              in_take;
    logic              out_free;
    logic [IDX_W+POS_W-1:0] pos_wide;

    upnp_step #(
        .MAX_LENGTH (MAX_LENGTH),
        .IDX_W      (IDX_W)
    ) u_step (
        .cfg          (cfg_reg),
        .cur          (scan_reg),
        .cur_index    (index_reg),
        .cur_dpos     (dpos_reg),
        .char_code    (s1_char_reg),
        .final_char   (s1_final_reg),
        .empty_string (s1_empty_reg),
        .nxt          (scan_next),
        .nxt_index    (index_next),
        .nxt_dpos     (dpos_next),
        .res_valid    (res_valid),
        .res_status   (res_status),
        .res_present  (res_present),
        .res_port     (res_port),
        .res_pos      (res_pos)
    );

    // The step only waits when it has a result and the output register is still held.
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!res_valid || out_free);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scheme_is_special <= RST_SCHEME_SPECIAL;
            cfg_reg.trailing_check_on <= RST_TRAILING_CHECK;
            cfg_reg.scheme_port       <= RST_SCHEME_PORT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCHEME_SPECIAL: cfg_reg.scheme_is_special <= cfg_data[0];
                CFG_TRAILING_CHECK: cfg_reg.trailing_check_on <= cfg_data[0];
                CFG_SCHEME_PORT:    cfg_reg.scheme_port       <= cfg_data[PORT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            scan_reg.phase      <= PH_LEAD;
            scan_reg.acc        <= '0;
            scan_reg.digit_seen <= 1'b0;
            scan_reg.dstatus    <= ST_OK;
            index_reg          <= '0;
            dpos_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                scan_reg  <= scan_next;
                index_reg <= index_next;
                dpos_reg  <= dpos_next;
            end
            if (s1_adv && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg  <= char_code;
            s1_final_reg <= final_char;
            s1_empty_reg <= empty_string;
        end
        if (s1_adv && res_valid)
        begin
            status_reg  <= res_status;
            present_reg <= res_present;
            port_reg    <= res_port;
            pos_reg     <= res_pos;
        end
    end

    assign pos_wide      = {{POS_W{1'b0}}, pos_reg};
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign port_present  = present_reg;
    assign port_value    = port_reg;
    assign stop_position = pos_wide[POS_W-1:0];

endmodule
